### rtl/fpla_pkg.sv
// Package for the free page list allocator: word types, opcode, status and
// register codes, widths and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpla_pkg;

    localparam int ADDR_BITS     = 39;
    localparam int COUNT_W       = 11;
    localparam int BASE_W        = 27;
    localparam int PAGES_W       = 11;
    localparam int LOWER_W       = 27;
    localparam int UPPER_W       = 28;
    localparam int CFG_DATA_W    = 28;
    localparam int MAX_PAGES_DEF = 1024;
    localparam int PAGE_BITS_DEF = 12;

    typedef enum logic [1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_INIT = 2'd2,
        OP_RSVD = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_PAGES = 2'd1,
        REG_LOWER = 2'd2,
        REG_UPPER = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_INIT
    } state_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [ADDR_BITS-1:0]   page_address;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   granted_address;
        status_t                status;
        logic [COUNT_W-1:0]     free_count;
    } out_word_t;

    typedef struct packed {
        logic [BASE_W-1:0]      region_base_page;
        logic [PAGES_W-1:0]     region_pages;
        logic [LOWER_W-1:0]     lower_limit_page;
        logic [UPPER_W-1:0]     upper_limit_page;
    } cfg_regs_t;

endpackage

`default_nettype wire

### rtl/free_page_list_allocator.sv
// Free page list allocator top level: request sequencer around the page ring.
// Depends on fpla_pkg, fpla_ram and fpla_cfg.
//
// Free pages are held first-in first-out in a ring RAM of page numbers with
// head, tail and count registers. Put, a refused request, a get on an
// empty list and an init of an empty region are answered from idle; a get
// that pops a page first reads the ring RAM, whose read data is registered;
// init writes N = min(region_pages, MAX_PAGES) pages through the ring's
// single write port, one page per cycle. One request is worked at a time;
// the next one is taken as soon as the result register is free or being
// drained in the same cycle, so a stalled result holds off the input side
// and also delays the last cycle of a get or an init. Configuration words
// are taken every cycle and must only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module free_page_list_allocator #(
    parameter int MAX_PAGES = fpla_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BITS = fpla_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire fpla_pkg::in_word_t              in_word,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output fpla_pkg::out_word_t                  out_word,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire fpla_pkg::cfg_idx_t              cfg_index,
    input  wire logic [fpla_pkg::CFG_DATA_W-1:0] cfg_data
);

    import fpla_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int PN_W  = ADDR_BITS - PAGE_BITS;
    localparam int CMP_W = (PN_W > UPPER_W) ? PN_W : UPPER_W;
    localparam int NW    = (CNT_W > PAGES_W) ? CNT_W : PAGES_W;

    cfg_regs_t cfg;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    init_idx_reg, init_idx_next;
    logic [CNT_W-1:0]    init_n_reg, init_n_next;
    status_t             init_stat_reg, init_stat_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg, out_word_next;

    logic                ring_wr_en;
    logic [IDX_W-1:0]    ring_wr_addr;
    logic [PN_W-1:0]     ring_wr_data;
    logic                ring_rd_en;
    logic [PN_W-1:0]     ring_rd_data;

    logic                out_free;
    logic                out_load;
    logic [PN_W-1:0]     put_page;
    logic                put_bad;
    logic [NW-1:0]       req_pages;
    logic                init_over;
    logic [CNT_W-1:0]    init_n;

    fpla_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    fpla_ram #(
        .WIDTH (PN_W),
        .DEPTH (MAX_PAGES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (head_reg),
        .rd_data (ring_rd_data)
    );

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        ring_inc = (idx == IDX_W'(MAX_PAGES - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // put checks: page alignment, then lower and upper limits
    assign put_page = in_word.page_address[ADDR_BITS-1:PAGE_BITS];
    assign put_bad  = (in_word.page_address[PAGE_BITS-1:0] != '0)
                   || (CMP_W'(put_page) <  CMP_W'(cfg.lower_limit_page))
                   || (CMP_W'(put_page) >= CMP_W'(cfg.upper_limit_page));

    // init region clipped to the ring size
    assign req_pages = NW'(cfg.region_pages);
    assign init_over = req_pages > NW'(MAX_PAGES);
    assign init_n    = init_over ? CNT_W'(MAX_PAGES) : CNT_W'(req_pages);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        init_idx_next  = init_idx_reg;
        init_n_next    = init_n_reg;
        init_stat_next = init_stat_reg;
        out_load       = 1'b0;
        out_word_next  = out_word_reg;
        ring_wr_en     = 1'b0;
        ring_wr_addr   = tail_reg;
        ring_wr_data   = put_page;
        ring_rd_en     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    out_word_next.granted_address = '0;
                    out_word_next.free_count      = COUNT_W'(count_reg);
                    unique case (in_word.opcode)
                        OP_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load             = 1'b1;
                                out_word_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                ring_rd_en = 1'b1;
                                state_next = S_GET;
                            end
                        end
                        OP_PUT:
                        begin
                            out_load = 1'b1;
                            if (put_bad)
                            begin
                                out_word_next.status = STAT_BAD;
                            end
                            else if (count_reg == CNT_W'(MAX_PAGES))
                            begin
                                out_word_next.status = STAT_FULL;
                            end
                            else
                            begin
                                ring_wr_en               = 1'b1;
                                tail_next                = ring_inc(tail_reg);
                                count_next               = count_reg + 1'b1;
                                out_word_next.status     = STAT_OK;
                                out_word_next.free_count = COUNT_W'(count_reg + 1'b1);
                            end
                        end
                        OP_INIT:
                        begin
                            init_idx_next  = '0;
                            init_n_next    = init_n;
                            init_stat_next = init_over ? STAT_FULL : STAT_OK;
                            if (init_n == '0)
                            begin
                                out_load                 = 1'b1;
                                head_next                = '0;
                                tail_next                = '0;
                                count_next               = '0;
                                out_word_next.status     = STAT_OK;
                                out_word_next.free_count = '0;
                            end
                            else
                            begin
                                state_next = S_INIT;
                            end
                        end
                        OP_RSVD:
                        begin
                            out_load             = 1'b1;
                            out_word_next.status = STAT_BAD;
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                // ring read data is valid here and holds until the next read
                if (out_free)
                begin
                    out_load                      = 1'b1;
                    out_word_next.granted_address = {ring_rd_data, {PAGE_BITS{1'b0}}};
                    out_word_next.status          = STAT_OK;
                    out_word_next.free_count      = COUNT_W'(count_reg - 1'b1);
                    head_next                     = ring_inc(head_reg);
                    count_next                    = count_reg - 1'b1;
                    state_next                    = S_IDLE;
                end
            end
            S_INIT:
            begin
                ring_wr_en   = 1'b1;
                ring_wr_addr = init_idx_reg[IDX_W-1:0];
                ring_wr_data = PN_W'(cfg.region_base_page) + PN_W'(init_idx_reg);
                if (init_idx_reg + 1'b1 == init_n_reg)
                begin
                    // last page: rewritten until the result register frees up
                    if (out_free)
                    begin
                        out_load                      = 1'b1;
                        out_word_next.granted_address = '0;
                        out_word_next.status          = init_stat_reg;
                        out_word_next.free_count      = COUNT_W'(init_n_reg);
                        head_next                     = '0;
                        tail_next  = (init_n_reg == CNT_W'(MAX_PAGES)) ? '0
                                                                  : init_n_reg[IDX_W-1:0];
                        count_next = init_n_reg;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    init_idx_next = init_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        init_idx_reg  <= init_idx_next;
        init_n_reg    <= init_n_next;
        init_stat_reg <= init_stat_next;
        if (out_load)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fpla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/fpla_cfg.sv
// Configuration register file of the free page list allocator.
// Depends on fpla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpla_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire fpla_pkg::cfg_idx_t             cfg_index,
    input  wire logic [fpla_pkg::CFG_DATA_W-1:0] cfg_data,
    output fpla_pkg::cfg_regs_t                 regs
);

    import fpla_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BASE:  regs_next.region_base_page = cfg_data[BASE_W-1:0];
                REG_PAGES: regs_next.region_pages     = cfg_data[PAGES_W-1:0];
                REG_LOWER: regs_next.lower_limit_page = cfg_data[LOWER_W-1:0];
                REG_UPPER: regs_next.upper_limit_page = cfg_data[UPPER_W-1:0];
                default:   regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fpla_chk.sv
// Port-level checks for the free page list allocator, bound to the top level.
// Depends on fpla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpla_chk (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire fpla_pkg::in_word_t              in_word,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire fpla_pkg::out_word_t             out_word
);

    import fpla_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // only a successful get hands out an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status != STAT_OK) |-> out_word.granted_address == '0)
        else $error("address given with a failing status");

    // empty is reported only with no free page
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status == STAT_EMPTY) |-> out_word.free_count == '0)
        else $error("empty status with pages free");

    // an unused opcode is answered in the next cycle with bad address
    a_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_word.opcode == OP_RSVD)
        |=> out_valid && (out_word.status == STAT_BAD))
        else $error("unused opcode not refused");

endmodule

bind free_page_list_allocator fpla_chk u_fpla_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

`default_nettype wire

### bench/tb.sv
// Testbench for the free page list allocator: directed and random get, put and
// init words checked against an in-bench copy of the page ring and its registers.
// Depends on fpla_pkg and free_page_list_allocator.
`timescale 1ns / 1ps

module tb;
    import fpla_pkg::*;

    localparam int RING_DEPTH = MAX_PAGES_DEF;
    localparam int PAGE_SHIFT = PAGE_BITS_DEF;
    localparam int PAGE_W     = ADDR_BITS - PAGE_SHIFT;
    localparam logic [UPPER_W-1:0] PAGE_SPACE = UPPER_W'(1) << PAGE_W;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = REG_BASE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    free_page_list_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // bench copy of the free list and registers
    logic [PAGE_W-1:0]  ring_pages [RING_DEPTH];
    int unsigned        ring_head  = 0;
    int unsigned        ring_tail  = 0;
    int unsigned        free_pages = 0;
    logic [BASE_W-1:0]  cur_base   = '0;
    logic [PAGES_W-1:0] cur_pages  = '0;
    logic [LOWER_W-1:0] cur_lower  = '0;
    logic [UPPER_W-1:0] cur_upper  = '0;

    out_word_t replies_due [$];
    int        mismatch_count = 0;
    int        burst_left     = 0;
    bit        hold_off_now   = 1'b0;

    function automatic logic [ADDR_BITS-1:0] page_byte_addr(input logic [PAGE_W-1:0] page);
        return {page, {PAGE_SHIFT{1'b0}}};
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        return ADDR_BITS'({$urandom(), $urandom()});
    endfunction

    // Applies one request word to the bench free list, returns the reply word.
    function automatic out_word_t apply_page_op(input in_word_t req);
        out_word_t         rsp;
        logic [PAGE_W-1:0] page;
        int unsigned       fill;
        rsp        = '0;
        rsp.status = STAT_OK;
        page       = req.page_address[ADDR_BITS-1:PAGE_SHIFT];
        case (req.opcode)
            OP_GET:
            begin
                if (free_pages == 0)
                    rsp.status = STAT_EMPTY;
                else
                begin
                    rsp.granted_address = page_byte_addr(ring_pages[ring_head]);
                    ring_head  = (ring_head + 1) % RING_DEPTH;
                    free_pages = free_pages - 1;
                end
            end
            OP_PUT:
            begin
                // limits are checked ahead of the full ring
                if (req.page_address[PAGE_SHIFT-1:0] != '0 || page < cur_lower
                    || page >= cur_upper)
                    rsp.status = STAT_BAD;
                else if (free_pages >= RING_DEPTH)
                    rsp.status = STAT_FULL;
                else
                begin
                    ring_pages[ring_tail] = page;
                    ring_tail  = (ring_tail + 1) % RING_DEPTH;
                    free_pages = free_pages + 1;
                end
            end
            OP_INIT:
            begin
                fill = 32'(cur_pages);
                if (fill > RING_DEPTH)
                begin
                    fill       = RING_DEPTH;
                    rsp.status = STAT_FULL;
                end
                // page numbers wrap at the top of the page space
                for (int i = 0; i < fill; i++)
                    ring_pages[i] = cur_base + PAGE_W'(i);
                ring_head  = 0;
                ring_tail  = fill % RING_DEPTH;
                free_pages = fill;
            end
            default:
                rsp.status = STAT_BAD;
        endcase
        rsp.free_count = COUNT_W'(free_pages);
        return rsp;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
    endtask

    // Sends one request word; bursts with random gaps between them.
    task automatic send_request(input opcode_t op, input logic [ADDR_BITS-1:0] addr);
        in_word_t req;
        int       gap;
        req.opcode       = op;
        req.page_address = addr;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        replies_due.push_back(apply_page_op(req));
    endtask

    task automatic drain_replies();
        in_valid   <= 1'b0;
        burst_left  = 0;
        while (replies_due.size() != 0) @(posedge clk);
    endtask

    // Writes all four registers back to back; only called once the block is idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] base_w,
                              input logic [CFG_DATA_W-1:0] pages_w,
                              input logic [CFG_DATA_W-1:0] lower_w,
                              input logic [CFG_DATA_W-1:0] upper_w);
        cfg_idx_t              order [4];
        logic [CFG_DATA_W-1:0] vals  [4];
        order = '{REG_BASE, REG_PAGES, REG_LOWER, REG_UPPER};
        vals  = '{base_w, pages_w, lower_w, upper_w};
        drain_replies();
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (order[k])
                REG_BASE:  cur_base  = vals[k][BASE_W-1:0];
                REG_PAGES: cur_pages = vals[k][PAGES_W-1:0];
                REG_LOWER: cur_lower = vals[k][LOWER_W-1:0];
                REG_UPPER: cur_upper = vals[k][UPPER_W-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed puts inside the limits, some misaligned or outside.
    function automatic logic [ADDR_BITS-1:0] pick_put_address();
        logic [PAGE_W:0]   span;
        logic [PAGE_W-1:0] page;
        int                pick;
        pick = $urandom_range(0, 9);
        span = (cur_upper > cur_lower) ? cur_upper - cur_lower : '0;
        if (span != 0 && pick < 8)
        begin
            page = cur_lower + PAGE_W'($urandom() % span);
            return page_byte_addr(page);
        end
        if (pick == 9)
        begin
            page = $urandom_range(0, 1) ? PAGE_W'(cur_lower - 1) : cur_upper[PAGE_W-1:0];
            return page_byte_addr(page) | ($urandom_range(0, 1) ? rand_addr() & 'hFFF : '0);
        end
        return rand_addr();
    endfunction

    task automatic test_empty_list();
        send_request(OP_GET, '0);
        send_request(OP_PUT, '0);       // upper limit still zero: refused
        send_request(OP_RSVD, '1);
        send_request(OP_INIT, '0);      // empty region
    endtask

    task automatic test_put_limits();
        set_config(5, 3, 16, 32);
        send_request(OP_PUT, page_byte_addr(15));
        send_request(OP_PUT, page_byte_addr(16));
        send_request(OP_PUT, page_byte_addr(31));
        send_request(OP_PUT, page_byte_addr(32));
        send_request(OP_PUT, page_byte_addr(20) | 1);
        send_request(OP_GET, '0);
        send_request(OP_GET, '1);
        send_request(OP_GET, '0);
        send_request(OP_INIT, '0);
        send_request(OP_GET, '0);
    endtask

    task automatic test_page_wrap();
        set_config(PAGE_SPACE - 2, 4, 0, PAGE_SPACE);
        send_request(OP_INIT, '0);
        send_request(OP_GET, '0);
        send_request(OP_GET, '0);
        send_request(OP_PUT, page_byte_addr('1));
        send_request(OP_PUT, '1);
        send_request(OP_GET, '0);
        send_request(OP_GET, '0);
        send_request(OP_GET, '0);
    endtask

    task automatic test_ring_full();
        set_config(PAGE_W'($urandom()), RING_DEPTH, 0, PAGE_SPACE);
        send_request(OP_INIT, '0);
        send_request(OP_PUT, page_byte_addr(PAGE_W'($urandom())));
        send_request(OP_GET, '0);
        send_request(OP_PUT, page_byte_addr(PAGE_W'($urandom())));
        // region larger than the ring: truncated, reported full
        set_config(PAGE_W'($urandom()), 2047, 0, PAGE_SPACE);
        send_request(OP_INIT, '0);
    endtask

    // Receiver holds off a long stretch while words keep coming, so input stalls.
    task automatic test_backpressure();
        set_config(PAGE_W'($urandom()), 8, 0, PAGE_SPACE);
        hold_off_now = 1'b1;
        burst_left   = 1000;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 0)
                send_request(OP_GET, rand_addr());
            else
                send_request(OP_PUT, pick_put_address());
        end
        burst_left = 0;
    endtask

    task automatic test_random_traffic();
        logic [PAGE_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic [PAGE_W-1:0]  lower;
        logic [UPPER_W-1:0] upper;
        logic [UPPER_W-1:0] top;
        bit                 fill;
        int                 pick;
        for (int phase = 0; phase < 6; phase++)
        begin
            fill = (phase % 3 == 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    lower = '0;
                    upper = PAGE_SPACE;
                end
                1:
                begin
                    lower = PAGE_W'($urandom());
                    top   = UPPER_W'(lower + $urandom_range(1, 4096));
                    upper = (top > PAGE_SPACE) ? PAGE_SPACE : top;
                end
                2:
                begin
                    lower = PAGE_W'($urandom());
                    upper = UPPER_W'($urandom());
                end
                default:
                begin
                    lower = PAGE_W'(PAGE_SPACE - $urandom_range(1, 64));
                    upper = PAGE_SPACE;
                end
            endcase
            base = $urandom_range(0, 1) ? PAGE_W'($urandom())
                                        : PAGE_W'(PAGE_SPACE - $urandom_range(1, 40));
            if (fill)
                pages = $urandom_range(0, 1) ? PAGES_W'(RING_DEPTH)
                                             : PAGES_W'($urandom_range(1000, 2047));
            else if ($urandom_range(0, 4) == 0)
                pages = PAGES_W'($urandom());
            else
                pages = PAGES_W'($urandom_range(0, 40));
            // spare high bits of the data are junk and must be ignored
            set_config({1'($urandom()), base}, {17'($urandom()), pages},
                       {1'($urandom()), lower}, upper);
            if (fill)
                send_request(OP_INIT, rand_addr());
            repeat (70)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    send_request(OP_GET, rand_addr());
                else if (pick < 88)
                    send_request(OP_PUT, pick_put_address());
                else if (pick < 96)
                    send_request(OP_INIT, rand_addr());
                else
                    send_request(OP_RSVD, rand_addr());
            end
        end
    endtask

    // Receiver stall pattern, plus one long hold-off on request
    initial
    begin : out_stall
        int stretch;
        int mode;
        int hold_left;
        stretch   = 0;
        mode      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_now)
            begin
                hold_left    = 300;
                hold_off_now = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch = $urandom_range(4, 40);
                    mode    = $urandom_range(0, 3);
                end
                stretch--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (stretch % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : reply_check
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
                flag_mismatch("unrequested reply word", '0, 64'(out_word));
            else
            begin
                want = replies_due.pop_front();
                if (out_word.granted_address !== want.granted_address)
                    flag_mismatch("granted_address", 64'(want.granted_address),
                                  64'(out_word.granted_address));
                if (out_word.status !== want.status)
                    flag_mismatch("status", 64'(want.status), 64'(out_word.status));
                if (out_word.free_count !== want.free_count)
                    flag_mismatch("free_count", 64'(want.free_count),
                                  64'(out_word.free_count));
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_put_limits();
        test_page_wrap();
        test_ring_full();
        test_backpressure();
        test_random_traffic();
        drain_replies();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### free_page_list_allocator.f
rtl/fpla_pkg.sv
rtl/fpla_ram.sv
rtl/fpla_cfg.sv
rtl/free_page_list_allocator.sv
rtl/fpla_chk.sv
bench/tb.sv
